/* hw/rtl/ps2mc_pkg.sv */
// Shared constants and types for the PS/2 mouse packet cursor block.
package ps2mc_pkg;

  // Default coordinate width; bounds run up to 2**COORD_BITS.
  localparam int COORD_BITS_DEF = 12;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  // Bounds after reset.
  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 768;

  // Header byte fields.
  localparam int         HDR_SYNC_BIT  = 3;
  localparam logic [7:0] HDR_OVERFLOW  = 8'hC0;
  localparam int         BUTTONS_W     = 3;

  // Position of the next byte within a packet.
  localparam logic [1:0] POS_HEADER = 2'd0;
  localparam logic [1:0] POS_XDELTA = 2'd1;
  localparam logic [1:0] POS_YDELTA = 2'd2;

  // Per-beat status flags.
  typedef struct packed {
    logic packet_done;
    logic motion_dropped;
    logic byte_skipped;
  } beat_flags_t;

endpackage

/* hw/rtl/ps2_mouse_packet_cursor.sv */
// Top level of the PS/2 mouse packet decoder with a clamped screen cursor.
//
// Usage: feed the bytes received on the mouse auxiliary port, one per beat, on
// the in_ channel. Every input beat produces exactly one out_ beat carrying the
// cursor position, the held buttons and three status flags: the beat ended a
// three-byte packet, that packet's motion was dropped for overflow, or the byte
// was thrown away because it could not be a header (sync bit clear).
// The cfg_ channel writes the screen width (index 0) or height (index 1); any
// write to either recenters the cursor. cfg_ready is always high. Writes are
// expected only while no byte is in flight.
// A byte accepted on in_ is held in the input register, then the decode and
// cursor clamp land in the result register, which drives out_valid.
// Throughput is one byte per cycle while the receiver keeps up; the input
// register accepts a new beat while a finished result waits at the output.
// When the receiver stalls, the result register holds and the input register
// fills, after which in_ready drops until the output drains. Reset (synchronous,
// active low) restores 1024 by 768 bounds, centers the cursor, clears the
// buttons and restarts packet alignment.
module ps2_mouse_packet_cursor
  import ps2mc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input byte channel.
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_aux_byte,
  // Result channel.
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_BITS-1:0]  out_pos_x,
  output logic [COORD_BITS-1:0]  out_pos_y,
  output logic [BUTTONS_W-1:0]   out_button_bits,
  output logic                   out_packet_done,
  output logic                   out_motion_dropped,
  output logic                   out_byte_skipped,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Input register stage.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;

  // Result register stage.
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] out_x_r;
  logic [COORD_BITS-1:0] out_y_r;
  logic [BUTTONS_W-1:0]  out_btn_r;
  beat_flags_t           out_flags_r;

  // Decode results for the byte in the input register.
  logic [COORD_BITS-1:0] pos_x_nxt;
  logic [COORD_BITS-1:0] pos_y_nxt;
  logic [BUTTONS_W-1:0]  buttons_nxt;
  beat_flags_t           flags_nxt;

  logic [COORD_BITS:0] width;
  logic [COORD_BITS:0] height;
  logic                recenter;
  logic                advance;
  logic                in_fire;

  // The byte in the input register moves on when the result slot is free or
  // its current beat is being taken this cycle.
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = in_fire || (s1_valid_r && !advance);
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  ps2mc_bounds #(
    .COORD_BITS(COORD_BITS)
  ) u_bounds (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_fire   (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .width_r    (width),
    .height_r   (height),
    .recenter_r (recenter)
  );

  ps2mc_track #(
    .COORD_BITS(COORD_BITS)
  ) u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (advance),
    .aux_byte    (s1_byte_r),
    .width       (width),
    .height      (height),
    .recenter    (recenter),
    .pos_x_nxt   (pos_x_nxt),
    .pos_y_nxt   (pos_y_nxt),
    .buttons_nxt (buttons_nxt),
    .flags_nxt   (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_aux_byte;
    end
    if (advance) begin
      out_x_r     <= pos_x_nxt;
      out_y_r     <= pos_y_nxt;
      out_btn_r   <= buttons_nxt;
      out_flags_r <= flags_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pos_x          = out_x_r;
  assign out_pos_y          = out_y_r;
  assign out_button_bits    = out_btn_r;
  assign out_packet_done    = out_flags_r.packet_done;
  assign out_motion_dropped = out_flags_r.motion_dropped;
  assign out_byte_skipped   = out_flags_r.byte_skipped;

endmodule

/* hw/rtl/ps2mc_bounds.sv */
// Screen bound registers with saturation and the recenter strobe.
module ps2mc_bounds
  import ps2mc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_fire,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [COORD_BITS:0]    width_r,
  output logic [COORD_BITS:0]    height_r,
  output logic                   recenter_r
);

  localparam int BW = COORD_BITS + 1;
  localparam int CW = (BW > CFG_DATA_W) ? BW : CFG_DATA_W;
  localparam int BOUND_MAX_I = 2 ** COORD_BITS;
  localparam int W_RST = (WIDTH_RESET > BOUND_MAX_I) ? BOUND_MAX_I : WIDTH_RESET;
  localparam int H_RST = (HEIGHT_RESET > BOUND_MAX_I) ? BOUND_MAX_I : HEIGHT_RESET;
  localparam logic [CW-1:0] BOUND_MAX = CW'(BOUND_MAX_I);

  logic [CW-1:0] data_ext;
  logic [CW-1:0] data_sat;
  logic          data_zero;
  logic [BW-1:0] width_nxt;
  logic [BW-1:0] height_nxt;
  logic          recenter_nxt;

  always_comb begin
    data_ext     = CW'(cfg_data);
    data_sat     = (data_ext > BOUND_MAX) ? BOUND_MAX : data_ext;
    data_zero    = (cfg_data == '0);
    width_nxt    = width_r;
    height_nxt   = height_r;
    recenter_nxt = 1'b0;
    if (cfg_fire) begin
      case (cfg_index)
        REG_SCREEN_WIDTH: begin
          if (!data_zero) width_nxt = BW'(data_sat);
          recenter_nxt = 1'b1;
        end
        REG_SCREEN_HEIGHT: begin
          if (!data_zero) height_nxt = BW'(data_sat);
          recenter_nxt = 1'b1;
        end
        default: recenter_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= BW'(W_RST);
      height_r   <= BW'(H_RST);
      recenter_r <= 1'b0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      recenter_r <= recenter_nxt;
    end
  end

endmodule

/* hw/rtl/ps2mc_track.sv */
// Packet assembly state and clamped cursor update for one byte.
module ps2mc_track
  import ps2mc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [7:0]            aux_byte,
  input  logic [COORD_BITS:0]   width,
  input  logic [COORD_BITS:0]   height,
  input  logic                  recenter,
  output logic [COORD_BITS-1:0] pos_x_nxt,
  output logic [COORD_BITS-1:0] pos_y_nxt,
  output logic [BUTTONS_W-1:0]  buttons_nxt,
  output beat_flags_t           flags_nxt
);

  localparam int SW = COORD_BITS + 2;
  localparam int BOUND_MAX_I = 2 ** COORD_BITS;
  localparam int W_RST = (WIDTH_RESET > BOUND_MAX_I) ? BOUND_MAX_I : WIDTH_RESET;
  localparam int H_RST = (HEIGHT_RESET > BOUND_MAX_I) ? BOUND_MAX_I : HEIGHT_RESET;

  logic [1:0]            pos_r,    pos_nxt;
  logic [7:0]            hdr_r,    hdr_nxt;
  logic [7:0]            xd_r,     xd_nxt;
  logic [COORD_BITS-1:0] col_r;
  logic [COORD_BITS-1:0] row_r;
  logic [BUTTONS_W-1:0]  btn_r;

  logic signed [SW-1:0]  dx;
  logic signed [SW-1:0]  dy;
  logic [COORD_BITS-1:0] col_mv;
  logic [COORD_BITS-1:0] row_mv;

  function automatic logic [COORD_BITS-1:0] clamp_axis(
    input logic [COORD_BITS-1:0] cur,
    input logic signed [SW-1:0]  delta,
    input logic [COORD_BITS:0]   bound
  );
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] lim;
    logic [COORD_BITS:0]  top;
    sum = $signed({2'b00, cur}) + delta;
    lim = $signed({1'b0, bound});
    top = bound - 1'b1;
    if (sum < 0) begin
      clamp_axis = '0;
    end else if (sum >= lim) begin
      clamp_axis = top[COORD_BITS-1:0];
    end else begin
      clamp_axis = sum[COORD_BITS-1:0];
    end
  endfunction

  always_comb begin
    // Deltas are doubled; Y is negated since screen rows grow downward.
    dx     = SW'($signed(xd_r)) <<< 1;
    dy     = -(SW'($signed(aux_byte)) <<< 1);
    col_mv = clamp_axis(col_r, dx, width);
    row_mv = clamp_axis(row_r, dy, height);

    pos_nxt     = pos_r;
    hdr_nxt     = hdr_r;
    xd_nxt      = xd_r;
    pos_x_nxt   = col_r;
    pos_y_nxt   = row_r;
    buttons_nxt = btn_r;
    flags_nxt   = '0;

    case (pos_r)
      POS_XDELTA: begin
        xd_nxt  = aux_byte;
        pos_nxt = POS_YDELTA;
      end
      POS_YDELTA: begin
        pos_nxt               = POS_HEADER;
        flags_nxt.packet_done = 1'b1;
        buttons_nxt           = hdr_r[BUTTONS_W-1:0];
        if ((hdr_r & HDR_OVERFLOW) != '0) begin
          flags_nxt.motion_dropped = 1'b1;
        end else begin
          pos_x_nxt = col_mv;
          pos_y_nxt = row_mv;
        end
      end
      default: begin
        // A header without the sync bit is discarded to regain alignment.
        if (!aux_byte[HDR_SYNC_BIT]) begin
          flags_nxt.byte_skipped = 1'b1;
          pos_nxt                = POS_HEADER;
        end else begin
          hdr_nxt = aux_byte;
          pos_nxt = POS_XDELTA;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HEADER;
      hdr_r <= '0;
      xd_r  <= '0;
      col_r <= COORD_BITS'(W_RST / 2);
      row_r <= COORD_BITS'(H_RST / 2);
      btn_r <= '0;
    end else if (recenter) begin
      col_r <= COORD_BITS'(width >> 1);
      row_r <= COORD_BITS'(height >> 1);
    end else if (fire) begin
      pos_r <= pos_nxt;
      hdr_r <= hdr_nxt;
      xd_r  <= xd_nxt;
      col_r <= pos_x_nxt;
      row_r <= pos_y_nxt;
      btn_r <= buttons_nxt;
    end
  end

endmodule

/* bench/ps2mc_checker.sv */
// Scoreboard for the PS/2 mouse packet cursor: predicts every result beat and compares it.
module ps2mc_checker
  import ps2mc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             in_aux_byte,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [COORD_BITS-1:0]  out_pos_x,
  input  logic [COORD_BITS-1:0]  out_pos_y,
  input  logic [BUTTONS_W-1:0]   out_button_bits,
  input  logic                   out_packet_done,
  input  logic                   out_motion_dropped,
  input  logic                   out_byte_skipped,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatch_count,
  output int                     beats_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BOUND_MAX = 1 << COORD_BITS;

  typedef struct packed {
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [BUTTONS_W-1:0]  buttons;
    beat_flags_t           flags;
  } cursor_report_t;

  int                   width_bound;
  int                   height_bound;
  int                   cursor_col;
  int                   cursor_row;
  logic [1:0]           next_pos;
  logic [7:0]           header;
  logic [7:0]           x_delta;
  logic [BUTTONS_W-1:0] held_buttons;
  cursor_report_t       cursor_reports_q[$];

  initial begin
    mismatch_count  = 0;
    beats_in_flight = 0;
  end

  function automatic int clamp_move(int cur, int delta, int bound);
    int v;
    v = cur + delta;
    if (v < 0) v = 0;
    if (v >= bound) v = bound - 1;
    return v;
  endfunction

  // Any write to a bound recenters the cursor, even when a zero keeps the old bound.
  task automatic load_bound(input logic [CFG_INDEX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
    int v;
    v = int'(data);
    if (idx != REG_SCREEN_WIDTH && idx != REG_SCREEN_HEIGHT) return;
    if (v > BOUND_MAX) v = BOUND_MAX;
    if (v != 0) begin
      if (idx == REG_SCREEN_WIDTH) width_bound = v;
      else height_bound = v;
    end
    cursor_col = width_bound / 2;
    cursor_row = height_bound / 2;
  endtask

  task automatic decode_aux_byte(input logic [7:0] b, output cursor_report_t rep);
    int dx;
    int dy;
    rep = '0;
    case (next_pos)
      POS_XDELTA: begin
        x_delta  = b;
        next_pos = POS_YDELTA;
      end
      POS_YDELTA: begin
        next_pos              = POS_HEADER;
        rep.flags.packet_done = 1'b1;
        held_buttons          = header[BUTTONS_W-1:0];
        if ((header & HDR_OVERFLOW) != 8'h00) begin
          rep.flags.motion_dropped = 1'b1;
        end else begin
          dx         = int'($signed(x_delta));
          dy         = int'($signed(b));
          cursor_col = clamp_move(cursor_col, 2 * dx, width_bound);
          cursor_row = clamp_move(cursor_row, -2 * dy, height_bound);
        end
      end
      default: begin
        if (!b[HDR_SYNC_BIT]) begin
          rep.flags.byte_skipped = 1'b1;
          next_pos               = POS_HEADER;
        end else begin
          header   = b;
          next_pos = POS_XDELTA;
        end
      end
    endcase
    rep.pos_x   = cursor_col[COORD_BITS-1:0];
    rep.pos_y   = cursor_row[COORD_BITS-1:0];
    rep.buttons = held_buttons;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    cursor_report_t rep;
    cursor_report_t want;
    if (!rst_n) begin
      width_bound  = WIDTH_RESET;
      height_bound = HEIGHT_RESET;
      cursor_col   = WIDTH_RESET / 2;
      cursor_row   = HEIGHT_RESET / 2;
      next_pos     = POS_HEADER;
      header       = '0;
      x_delta      = '0;
      held_buttons = '0;
      cursor_reports_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) load_bound(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        decode_aux_byte(in_aux_byte, rep);
        cursor_reports_q.push_back(rep);
      end
      if (out_valid && out_ready) begin
        if (cursor_reports_q.size() == 0) begin
          $error("result beat with no byte waiting for it");
          mismatch_count++;
        end else begin
          want = cursor_reports_q.pop_front();
          check_field("pos_x", 16'(want.pos_x), 16'(out_pos_x));
          check_field("pos_y", 16'(want.pos_y), 16'(out_pos_y));
          check_field("button_bits", 16'(want.buttons), 16'(out_button_bits));
          check_field("packet_done", 16'(want.flags.packet_done), 16'(out_packet_done));
          check_field("motion_dropped", 16'(want.flags.motion_dropped),
                      16'(out_motion_dropped));
          check_field("byte_skipped", 16'(want.flags.byte_skipped),
                      16'(out_byte_skipped));
        end
      end
    end
    beats_in_flight = cursor_reports_q.size();
  end

endmodule

/* bench/tb_top.sv */
// Top of the PS/2 mouse packet cursor bench: clock, reset, byte and register traffic, verdict.
module tb_top
  import ps2mc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Indexes past the two bounds; writes there must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [7:0]               in_aux_byte;
  logic                     out_valid;
  logic                     out_ready;
  logic [COORD_BITS_DEF-1:0] out_pos_x;
  logic [COORD_BITS_DEF-1:0] out_pos_y;
  logic [BUTTONS_W-1:0]     out_button_bits;
  logic                     out_packet_done;
  logic                     out_motion_dropped;
  logic                     out_byte_skipped;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  int mismatch_count;
  int beats_in_flight;

  // Knobs shared by the sender and the receiver processes.
  bit tx_throttle;
  bit rx_throttle;
  int hold_cycles;

  ps2_mouse_packet_cursor u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_aux_byte        (in_aux_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pos_x          (out_pos_x),
    .out_pos_y          (out_pos_y),
    .out_button_bits    (out_button_bits),
    .out_packet_done    (out_packet_done),
    .out_motion_dropped (out_motion_dropped),
    .out_byte_skipped   (out_byte_skipped),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  ps2mc_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_aux_byte        (in_aux_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pos_x          (out_pos_x),
    .out_pos_y          (out_pos_y),
    .out_button_bits    (out_button_bits),
    .out_packet_done    (out_packet_done),
    .out_motion_dropped (out_motion_dropped),
    .out_byte_skipped   (out_byte_skipped),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatch_count     (mismatch_count),
    .beats_in_flight    (beats_in_flight)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Idle stretches are mostly a few cycles, with the occasional long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offers one byte and returns at the rising edge where the beat is taken.
  // Valid stays up between back-to-back bytes; it only drops for a gap or in stop_bytes.
  task automatic send_byte(input logic [7:0] b);
    int n;
    n = (tx_throttle && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    @(negedge clk);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_aux_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic stop_bytes();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Register writes go in only once every byte sent so far has come back out,
  // so the block is idle when the bounds change under it.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    while (beats_in_flight != 0) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Edge cases first: bytes with the sync bit clear, extreme deltas in both
  // directions, each overflow bit alone and together, and all button bits.
  task automatic directed_bytes();
    logic [7:0] seq [0:22];
    seq = '{8'h00, 8'hF7,              // both dropped as headers without sync
            8'h08, 8'h7F, 8'h80,       // largest right move, largest downward move
            8'h0F, 8'h80, 8'h7F,       // all buttons, largest left and upward move
            8'h4F, 8'h12, 8'h34,       // X overflow: buttons kept, motion dropped
            8'h88, 8'hFF, 8'hFF,       // Y overflow
            8'hCD, 8'h00, 8'h00,       // both overflow bits
            8'h3A, 8'hFF, 8'h01,       // sign bits in the header are ignored
            8'hFF, 8'h01, 8'h01};      // every header bit set
    foreach (seq[i]) send_byte(seq[i]);
    stop_bytes();
  endtask

  // Mostly well-formed packets with random content. Deltas either take any
  // value or push hard in a direction that holds for a while, so the cursor
  // reaches the screen edges. About one step in ten is junk that may also
  // break a packet and force the decoder to find its way back.
  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned sent;
    logic [7:0]  hdr;
    logic [7:0]  xd;
    logic [7:0]  yd;
    bit          dir_x;
    bit          dir_y;
    sent  = 0;
    dir_x = 1'($urandom_range(0, 1));
    dir_y = 1'($urandom_range(0, 1));
    while (sent < n_bytes) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        hdr               = 8'($urandom_range(0, 255));
        hdr[HDR_SYNC_BIT] = 1'b1;
        if ($urandom_range(0, 7) != 0) hdr = hdr & ~HDR_OVERFLOW;
        if ($urandom_range(0, 15) == 0) dir_x = ~dir_x;
        if ($urandom_range(0, 15) == 0) dir_y = ~dir_y;
        if ($urandom_range(0, 1) == 0) begin
          xd = 8'($urandom_range(0, 255));
          yd = 8'($urandom_range(0, 255));
        end else begin
          xd = 8'($urandom_range(96, 127));
          yd = 8'($urandom_range(96, 127));
          if (dir_x) xd = -xd;
          if (dir_y) yd = -yd;
        end
        send_byte(hdr);
        send_byte(xd);
        send_byte(yd);
        sent += 3;
      end
    end
    stop_bytes();
  endtask

  // Result side. A hold-off request from the main sequence wins over the
  // random stalls, and is counted out here while the sender keeps pushing.
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
      end else if (rx_throttle && $urandom_range(0, 4) == 0) begin
        n = gap_len();
      end else begin
        n = 0;
      end
      if (n != 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #20_000_000;
    $display("** ps2_mouse_packet_cursor: FAILED **");
    $finish;
  end

  initial begin
    int waited;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_aux_byte = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    tx_throttle = 1'b0;
    rx_throttle = 1'b0;
    hold_cycles = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset bounds, no idling on either side.
    directed_bytes();

    // A zero width keeps the old width; an oversized height saturates.
    rx_throttle = 1'b1;
    tx_throttle = 1'b1;
    write_reg(REG_SCREEN_WIDTH, '0);
    write_reg(REG_SCREEN_HEIGHT, '1);
    random_traffic(300);

    // One-pixel screen: every move clamps on both sides.
    rx_throttle = 1'b0;
    tx_throttle = 1'b0;
    write_reg(REG_SCREEN_WIDTH, 13'd1);
    write_reg(REG_SCREEN_HEIGHT, 13'd1);
    random_traffic(120);

    // Largest bounds, one of them written just past the top.
    rx_throttle = 1'b1;
    tx_throttle = 1'b1;
    write_reg(REG_SCREEN_WIDTH, 13'd4097);
    write_reg(REG_SCREEN_HEIGHT, 13'd4096);
    random_traffic(300);

    // The receiver goes quiet for a long stretch while bytes keep coming,
    // so the block fills up and has to hold off its input.
    tx_throttle = 1'b0;
    hold_cycles = 400;
    random_traffic(240);
    tx_throttle = 1'b1;

    // Writes to unused indexes must neither change a bound nor recenter.
    write_reg(REG_SPARE_2, CFG_DATA_W'($urandom_range(0, 8191)));
    write_reg(REG_SPARE_3, CFG_DATA_W'($urandom_range(0, 8191)));
    random_traffic(60);

    // Random widths over the whole register range, with short screens.
    repeat (4) begin
      write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'($urandom_range(0, 8191)));
      write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'($urandom_range(1, 300)));
      random_traffic(170);
    end

    // Drain whatever is still in the block, then give it a few quiet cycles
    // so that a stray extra beat would still be caught.
    waited = 0;
    while (beats_in_flight != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    if (beats_in_flight != 0) $error("%0d result beats never arrived", beats_in_flight);
    repeat (10) @(negedge clk);

    if (mismatch_count == 0 && beats_in_flight == 0) begin
      $display("** ps2_mouse_packet_cursor: PASSED **");
    end else begin
      $display("** ps2_mouse_packet_cursor: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ps2mc_pkg.sv
hw/rtl/ps2mc_bounds.sv
hw/rtl/ps2mc_track.sv
hw/rtl/ps2_mouse_packet_cursor.sv
bench/ps2mc_checker.sv
bench/tb_top.sv
